// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL files that carry checks.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fbd_pkg.sv -----
// Shared widths, constants, reciprocal table and candidate type for the
// fractional baud divider search. No dependencies.
`default_nettype none

package fbd_pkg;

    localparam int PCLK_W  = 27;
    localparam int BAUD_W  = 22;
    localparam int LATCH_W = 16;
    localparam int FLD_W   = 4;

    localparam int MAX_ADD = 15;
    localparam int MUL_MAX = 15;
    localparam int N_CAND  = (MAX_ADD + 1) * MUL_MAX;
    localparam int K_MAX   = MAX_ADD + MUL_MAX;
    localparam int K_W     = 5;

    localparam logic [PCLK_W-1:0]  PCLK_RESET = PCLK_W'(60000000);
    localparam logic [LATCH_W-1:0] LATCH_MAX  = '1;

    // clk / baud divider: 3 quotient bits per stage
    localparam int DIV_BPS    = 3;
    localparam int DIV_STAGES = PCLK_W / DIV_BPS;

    localparam int PROD_W = BAUD_W + FLD_W;   // m * rem
    localparam int F_W    = PCLK_W + FLD_W;   // floor(clk*m/baud)
    localparam int Y_W    = F_W + 1;          // F + 8k
    localparam int Z_W    = Y_W - 4;          // Y / 16
    localparam int RCP_SH = Z_W;
    localparam int RCP_W  = RCP_SH + 1;
    localparam int Q_W    = Z_W;              // full divisor
    localparam int S_W    = K_W + 4;          // Y mod 16k
    localparam int EN_W   = BAUD_W + K_W + 3; // error numerator
    localparam int ED_W   = Y_W;              // error denominator

    localparam int FRAC_LAT  = 3;
    localparam int CAND_LAT  = 4;
    localparam int TREE_LVL  = $clog2(N_CAND);
    localparam int TREE_LEAVES = 2 ** TREE_LVL;
    localparam int PIPE_LAT  = 1 + DIV_STAGES + FRAC_LAT + CAND_LAT + TREE_LVL;

    // floor(2^RCP_SH / k), indexed by k = add + multiply
    localparam logic [RCP_W-1:0] RECIP [2**K_W] = '{
        RCP_W'(0),
        RCP_W'((2**RCP_SH) / 1),  RCP_W'((2**RCP_SH) / 2),  RCP_W'((2**RCP_SH) / 3),
        RCP_W'((2**RCP_SH) / 4),  RCP_W'((2**RCP_SH) / 5),  RCP_W'((2**RCP_SH) / 6),
        RCP_W'((2**RCP_SH) / 7),  RCP_W'((2**RCP_SH) / 8),  RCP_W'((2**RCP_SH) / 9),
        RCP_W'((2**RCP_SH) / 10), RCP_W'((2**RCP_SH) / 11), RCP_W'((2**RCP_SH) / 12),
        RCP_W'((2**RCP_SH) / 13), RCP_W'((2**RCP_SH) / 14), RCP_W'((2**RCP_SH) / 15),
        RCP_W'((2**RCP_SH) / 16), RCP_W'((2**RCP_SH) / 17), RCP_W'((2**RCP_SH) / 18),
        RCP_W'((2**RCP_SH) / 19), RCP_W'((2**RCP_SH) / 20), RCP_W'((2**RCP_SH) / 21),
        RCP_W'((2**RCP_SH) / 22), RCP_W'((2**RCP_SH) / 23), RCP_W'((2**RCP_SH) / 24),
        RCP_W'((2**RCP_SH) / 25), RCP_W'((2**RCP_SH) / 26), RCP_W'((2**RCP_SH) / 27),
        RCP_W'((2**RCP_SH) / 28), RCP_W'((2**RCP_SH) / 29), RCP_W'((2**RCP_SH) / 30),
        RCP_W'((2**RCP_SH) / 31)
    };

    typedef struct packed {
        logic             ok;
        logic [EN_W-1:0]  err_n;
        logic [ED_W-1:0]  err_d;
        logic [Q_W-1:0]   div;
        logic [FLD_W-1:0] add;
        logic [FLD_W-1:0] mul;
    } t_cand;

endpackage

`default_nettype wire

// ----- hdl/fractional_baud_divider_search_core.sv -----
// Fractional baud divider search, top level.
// Depends on fbd_pkg, fbd_divider, fbd_frac, fbd_cand, fbd_tree, assert_macros.svh.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one target baud word; output
//   channel (o_valid/i_ready) returns one word per input: divisor, add,
//   multiply, clipped and no-solution flags. i_cfg_we writes pclk_hz
//   (reset value 60 MHz); write it only while no word is in flight.
//   All 240 (add, multiply) pairs are evaluated in parallel lanes and a
//   registered tree keeps the first pair with the smallest exact error.
//   Pipeline: 1 entry + 9 divider + 3 fraction + 4 candidate + 8 tree registers,
//   then the output register that drives o_valid.
//   Throughput: one word per cycle while the pipeline advances; the shared
//   clk/baud divider and the lanes are fully pipelined.
//   A stalled receiver holds the output register; the pipeline keeps
//   moving while its last stage is empty, so bubbles are squeezed out
//   and new words are still taken. Reset clears all valid bits and
//   restores pclk_hz. A zero baud returns a no-solution word.
`default_nettype none
`include "assert_macros.svh"

module fractional_baud_divider_search_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fbd_pkg::BAUD_W-1:0]  i_target_baud,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fbd_pkg::LATCH_W-1:0] o_divisor_latch,
    output logic [fbd_pkg::FLD_W-1:0]   o_divide_add,
    output logic [fbd_pkg::FLD_W-1:0]   o_multiply,
    output logic                        o_divisor_clipped,
    output logic                        o_no_solution,
    input  logic                        i_cfg_we,
    input  logic [fbd_pkg::PCLK_W-1:0]  i_cfg_wdata
);
    import fbd_pkg::*;

    logic [PCLK_W-1:0] r_pclk;
    logic              r_vld [1:PIPE_LAT];
    logic              r_zro [1:PIPE_LAT];
    logic              w_last_vld;
    logic              w_out_take;
    logic              w_en;

    logic [PCLK_W-1:0] w_quo;
    logic [BAUD_W-1:0] w_rem;
    logic [BAUD_W-1:0] w_dbaud;
    logic [F_W-1:0]    w_f  [MUL_MAX];
    logic [BAUD_W-1:0] w_rm [MUL_MAX];
    logic [BAUD_W-1:0] w_fbaud;
    logic [BAUD_W-1:0] r_rm_d   [CAND_LAT-1][MUL_MAX];
    logic [BAUD_W-1:0] r_baud_d [CAND_LAT-1];
    t_cand             w_leaf [N_CAND];
    t_cand             w_best;

    logic               r_out_vld;
    logic [LATCH_W-1:0] r_div;
    logic [FLD_W-1:0]   r_add;
    logic [FLD_W-1:0]   r_mul;
    logic               r_clip;
    logic               r_nosol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pclk <= PCLK_RESET;
        end else if (i_cfg_we) begin
            r_pclk <= i_cfg_wdata;
        end
    end

    // global advance: output free, or nothing arriving at it
    assign w_last_vld = r_vld[PIPE_LAT];
    assign w_out_take = !r_out_vld || i_ready;
    assign w_en       = w_out_take || !w_last_vld;
    assign o_ready    = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= PIPE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= i_valid;
            for (int i = 2; i <= PIPE_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zro[1] <= (i_target_baud == '0);
            for (int i = 2; i <= PIPE_LAT; i++) begin
                r_zro[i] <= r_zro[i-1];
            end
        end
    end

    fbd_divider u_div (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_pclk),
        .i_divisor  (i_target_baud),
        .o_quo      (w_quo),
        .o_rem      (w_rem),
        .o_divisor  (w_dbaud)
    );

    fbd_frac u_frac (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_quo  (w_quo),
        .i_rem  (w_rem),
        .i_baud (w_dbaud),
        .o_f    (w_f),
        .o_rm   (w_rm),
        .o_baud (w_fbaud)
    );

    // remainder and baud wait for the last candidate stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rm_d[0]   <= w_rm;
            r_baud_d[0] <= w_fbaud;
            for (int i = 1; i < CAND_LAT - 1; i++) begin
                r_rm_d[i]   <= r_rm_d[i-1];
                r_baud_d[i] <= r_baud_d[i-1];
            end
        end
    end

    // lane order: add outer, multiply inner
    for (genvar a = 0; a <= MAX_ADD; a++) begin : g_add
        for (genvar m = 1; m <= MUL_MAX; m++) begin : g_mul
            fbd_cand u_cand (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_k    (K_W'(a + m)),
                .i_add  (FLD_W'(a)),
                .i_mul  (FLD_W'(m)),
                .i_f    (w_f[m-1]),
                .i_rm   (r_rm_d[CAND_LAT-2][m-1]),
                .i_baud (r_baud_d[CAND_LAT-2]),
                .o_cand (w_leaf[a*MUL_MAX+m-1])
            );
        end
    end

    fbd_tree u_tree (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_leaf (w_leaf),
        .o_best (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_take) begin
            r_out_vld <= w_last_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take && w_last_vld) begin
            if (r_zro[PIPE_LAT] || !w_best.ok) begin
                r_div   <= '0;
                r_add   <= '0;
                r_mul   <= FLD_W'(1);
                r_clip  <= 1'b0;
                r_nosol <= 1'b1;
            end else begin
                r_add   <= w_best.add;
                r_mul   <= w_best.mul;
                r_nosol <= 1'b0;
                if (|w_best.div[Q_W-1:LATCH_W]) begin
                    r_div  <= LATCH_MAX;
                    r_clip <= 1'b1;
                end else begin
                    r_div  <= w_best.div[LATCH_W-1:0];
                    r_clip <= 1'b0;
                end
            end
        end
    end

    assign o_valid           = r_out_vld;
    assign o_divisor_latch   = r_div;
    assign o_divide_add      = r_add;
    assign o_multiply        = r_mul;
    assign o_divisor_clipped = r_clip;
    assign o_no_solution     = r_nosol;

    `ASSERT_NEXT(a_pipe_adv, i_clk, i_rst_n, w_en && r_vld[PIPE_LAT-1], r_vld[PIPE_LAT], "word lost at tree root")
    `ASSERT_SAME(a_clip_sat, i_clk, i_rst_n, o_valid && o_divisor_clipped, o_divisor_latch == LATCH_MAX && !o_no_solution, "clipped word not saturated")
    `ASSERT_SAME(a_nosol_fmt, i_clk, i_rst_n, o_valid && o_no_solution, o_divisor_latch == '0 && o_divide_add == '0 && o_multiply == FLD_W'(1), "bad no-solution word")
    `ASSERT_SAME(a_mul_nz, i_clk, i_rst_n, o_valid, o_multiply != '0, "multiply of zero")

endmodule

`default_nettype wire

// ----- hdl/fbd_divider.sv -----
// Pipelined restoring divider: peripheral clock / target baud.
// Depends on fbd_pkg.
`default_nettype none

module fbd_divider (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fbd_pkg::PCLK_W-1:0]  i_dividend,
    input  logic [fbd_pkg::BAUD_W-1:0]  i_divisor,
    output logic [fbd_pkg::PCLK_W-1:0]  o_quo,
    output logic [fbd_pkg::BAUD_W-1:0]  o_rem,
    output logic [fbd_pkg::BAUD_W-1:0]  o_divisor
);
    import fbd_pkg::*;

    logic [PCLK_W-1:0] r_dvd [DIV_STAGES+1];
    logic [PCLK_W-1:0] r_quo [DIV_STAGES+1];
    logic [BAUD_W-1:0] r_rem [DIV_STAGES+1];
    logic [BAUD_W-1:0] r_dsr [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd[0] <= i_dividend;
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_dsr[0] <= i_divisor;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [PCLK_W-1:0] n_dvd;
        logic [PCLK_W-1:0] n_quo;
        logic [BAUD_W-1:0] n_rem;

        always_comb begin
            logic [BAUD_W:0] try_v;
            n_dvd = r_dvd[g];
            n_quo = r_quo[g];
            n_rem = r_rem[g];
            for (int j = 0; j < DIV_BPS; j++) begin
                try_v = {n_rem, n_dvd[PCLK_W-1]};
                n_dvd = {n_dvd[PCLK_W-2:0], 1'b0};
                if (try_v >= {1'b0, r_dsr[g]}) begin
                    try_v = try_v - {1'b0, r_dsr[g]};
                    n_quo = {n_quo[PCLK_W-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[PCLK_W-2:0], 1'b0};
                end
                n_rem = try_v[BAUD_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvd[g+1] <= n_dvd;
                r_quo[g+1] <= n_quo;
                r_rem[g+1] <= n_rem;
                r_dsr[g+1] <= r_dsr[g];
            end
        end
    end

    assign o_quo     = r_quo[DIV_STAGES];
    assign o_rem     = r_rem[DIV_STAGES];
    assign o_divisor = r_dsr[DIV_STAGES];

endmodule

`default_nettype wire

// ----- hdl/fbd_frac.sv -----
// Per-multiplier split of clk*m/baud into floor and remainder, 3 stages.
// Depends on fbd_pkg.
`default_nettype none

module fbd_frac (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fbd_pkg::PCLK_W-1:0]  i_quo,
    input  logic [fbd_pkg::BAUD_W-1:0]  i_rem,
    input  logic [fbd_pkg::BAUD_W-1:0]  i_baud,
    output logic [fbd_pkg::F_W-1:0]     o_f   [fbd_pkg::MUL_MAX],
    output logic [fbd_pkg::BAUD_W-1:0]  o_rm  [fbd_pkg::MUL_MAX],
    output logic [fbd_pkg::BAUD_W-1:0]  o_baud
);
    import fbd_pkg::*;

    logic [PROD_W-1:0] r1_prod [MUL_MAX];
    logic [PCLK_W-1:0] r1_quo, r2_quo;
    logic [BAUD_W-1:0] r1_baud, r2_baud, r3_baud;
    logic [FLD_W-1:0]  n2_c [MUL_MAX];
    logic [FLD_W-1:0]  r2_c [MUL_MAX];
    logic [BAUD_W-1:0] n2_rm [MUL_MAX];
    logic [BAUD_W-1:0] r2_rm [MUL_MAX];
    logic [BAUD_W-1:0] r3_rm [MUL_MAX];
    logic [F_W-1:0]    r3_f  [MUL_MAX];

    // stage 1: m * (clk mod baud)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_quo  <= i_quo;
            r1_baud <= i_baud;
            for (int i = 0; i < MUL_MAX; i++) begin
                r1_prod[i] <= PROD_W'(i_rem) * PROD_W'(i + 1);
            end
        end
    end

    // stage 2: 4-bit restoring divide of each product by baud
    always_comb begin
        logic [PROD_W-1:0] p;
        logic [PROD_W-1:0] sh;
        for (int i = 0; i < MUL_MAX; i++) begin
            p = r1_prod[i];
            n2_c[i] = '0;
            for (int j = FLD_W - 1; j >= 0; j--) begin
                sh = PROD_W'(r1_baud) << j;
                if (p >= sh) begin
                    p = p - sh;
                    n2_c[i][j] = 1'b1;
                end
            end
            n2_rm[i] = p[BAUD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_quo  <= r1_quo;
            r2_baud <= r1_baud;
            r2_c    <= n2_c;
            r2_rm   <= n2_rm;
        end
    end

    // stage 3: floor(clk*m/baud) = m*q + carry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_baud <= r2_baud;
            r3_rm   <= r2_rm;
            for (int i = 0; i < MUL_MAX; i++) begin
                r3_f[i] <= F_W'(r2_quo) * F_W'(i + 1) + F_W'(r2_c[i]);
            end
        end
    end

    assign o_f    = r3_f;
    assign o_rm   = r3_rm;
    assign o_baud = r3_baud;

endmodule

`default_nettype wire

// ----- hdl/fbd_cand.sv -----
// One (add, multiply) candidate: rounded divisor and exact error fraction.
// Four stages. Depends on fbd_pkg.
`default_nettype none

module fbd_cand (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fbd_pkg::K_W-1:0]     i_k,
    input  logic [fbd_pkg::FLD_W-1:0]   i_add,
    input  logic [fbd_pkg::FLD_W-1:0]   i_mul,
    input  logic [fbd_pkg::F_W-1:0]     i_f,
    input  logic [fbd_pkg::BAUD_W-1:0]  i_rm,
    input  logic [fbd_pkg::BAUD_W-1:0]  i_baud,
    output fbd_pkg::t_cand              o_cand
);
    import fbd_pkg::*;

    logic [Y_W-1:0]  r1_y, r2_y, r3_y;
    logic [Q_W-1:0]  r2_q0, r3_d, n3_d;
    logic [S_W-1:0]  r3_s, n3_s;
    logic [Z_W+RCP_W-1:0] w_prod;
    logic [K_W+2:0]  w_e8;
    logic [K_W+2:0]  w_diff;
    logic [EN_W-1:0] w_err_n;
    t_cand           r4_cand;

    assign w_e8 = {i_k, 3'b000};

    // stage 1: Y = floor(clk*m/baud) + 8k
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_y <= Y_W'(i_f) + Y_W'(w_e8);
        end
    end

    // stage 2: estimate (Y/16)/k by reciprocal, low by at most one
    assign w_prod = (Z_W+RCP_W)'(r1_y[Y_W-1:4]) * (Z_W+RCP_W)'(RECIP[i_k]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_y  <= r1_y;
            r2_q0 <= w_prod[RCP_SH +: Q_W];
        end
    end

    // stage 3: correct the estimate, form Y mod 16k
    always_comb begin
        logic [Z_W-1:0] rr;
        logic [K_W:0]   rlo;
        logic [K_W-1:0] rk;
        rr  = r2_y[Y_W-1:4] - r2_q0 * Z_W'(i_k);
        rlo = rr[K_W:0];
        if (rlo >= {1'b0, i_k}) begin
            n3_d = r2_q0 + Q_W'(1);
            rk   = K_W'(rlo - {1'b0, i_k});
        end else begin
            n3_d = r2_q0;
            rk   = rlo[K_W-1:0];
        end
        n3_s = {rk, r2_y[3:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_y <= r2_y;
            r3_d <= n3_d;
            r3_s <= n3_s;
        end
    end

    // stage 4: |(s - 8k)*baud + rm| over 16dk = Y - s
    always_comb begin
        if ({1'b0, r3_s} >= {2'b00, w_e8}) begin
            w_diff  = (K_W+3)'(r3_s - {1'b0, w_e8});
            w_err_n = EN_W'(w_diff) * EN_W'(i_baud) + EN_W'(i_rm);
        end else begin
            w_diff  = (K_W+3)'({1'b0, w_e8} - r3_s);
            w_err_n = EN_W'(w_diff) * EN_W'(i_baud) - EN_W'(i_rm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_cand.ok    <= |r3_d;
            r4_cand.err_n <= w_err_n;
            r4_cand.err_d <= r3_y - Y_W'(r3_s);
            r4_cand.div   <= r3_d;
            r4_cand.add   <= i_add;
            r4_cand.mul   <= i_mul;
        end
    end

    assign o_cand = r4_cand;

endmodule

`default_nettype wire

// ----- hdl/fbd_tree.sv -----
// Registered reduction tree keeping the first candidate with least error.
// Depends on fbd_pkg.
`default_nettype none

module fbd_tree (
    input  logic            i_clk,
    input  logic            i_en,
    input  fbd_pkg::t_cand  i_leaf [fbd_pkg::N_CAND],
    output fbd_pkg::t_cand  o_best
);
    import fbd_pkg::*;

    t_cand r_node [1:TREE_LEAVES-1];

    // right wins only when valid and strictly better; ties keep the earlier one
    function automatic t_cand f_pick(input t_cand l, input t_cand r);
        logic [EN_W+ED_W-1:0] lhs;
        logic [EN_W+ED_W-1:0] rhs;
        t_cand b;
        lhs = (EN_W+ED_W)'(r.err_n) * (EN_W+ED_W)'(l.err_d);
        rhs = (EN_W+ED_W)'(l.err_n) * (EN_W+ED_W)'(r.err_d);
        b = l;
        if (r.ok && (!l.ok || lhs < rhs)) begin
            b = r;
        end
        return b;
    endfunction

    for (genvar n = 1; n < TREE_LEAVES; n++) begin : g_node
        t_cand w_l;
        t_cand w_r;
        if (2 * n >= TREE_LEAVES) begin : g_leaf
            if (2 * n - TREE_LEAVES < N_CAND) begin : g_lv
                assign w_l = i_leaf[2*n-TREE_LEAVES];
            end else begin : g_lp
                assign w_l = t_cand'('0);
            end
            if (2 * n + 1 - TREE_LEAVES < N_CAND) begin : g_rv
                assign w_r = i_leaf[2*n+1-TREE_LEAVES];
            end else begin : g_rp
                assign w_r = t_cand'('0);
            end
        end else begin : g_inner
            assign w_l = r_node[2*n];
            assign w_r = r_node[2*n+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_node[n] <= f_pick(w_l, w_r);
            end
        end
    end

    assign o_best = r_node[1];

endmodule

`default_nettype wire
